// ----- hw/rtl/hpt_pkg.sv -----
// ---------------------------------------------------------------------------
// hpt_pkg
// shared constants and control types of the homogeneous point transform
// ---------------------------------------------------------------------------
`default_nettype none
package hpt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int PROD_W        = 2 * COORD_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int MAG_W         = SUM_W - 1;
   localparam int QUO_BITS      = COORD_W + 1;
   localparam int NUM_REGS      = 8;
   localparam int REG_W         = 64;
   localparam int CSR_IDX_W     = 8;
   localparam int REG_IDX_W     = 3;

   typedef struct packed {
      logic       valid;
      logic       w_zero;
      logic [2:0] neg;
   } hpt_mac_ctl_type;

   typedef struct packed {
      logic valid;
      logic w_zero;
      logic neg;
   } hpt_div_ctl_type;

endpackage
`default_nettype wire

// ----- hw/rtl/homogeneous_point_transform.sv -----
// ---------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix transform of a Q point with perspective divide by w
// ---------------------------------------------------------------------------
//  channel | ports                          | role
//  req     | req_valid/ready, req_point_*   | point in
//  rsp     | rsp_valid/ready, rsp_out_*     | transformed point out
//  csr     | csr_valid/ready, index, data   | matrix register write
//
//  one point per cycle unless the output stalls; 3 multiply/sum stages,
//  34 divider stages (load, then one quotient bit each), one output register
//  synchronous reset clears valid bits and loads the identity matrix
//  a stalled output freezes the whole pipeline; nothing is dropped
// ---------------------------------------------------------------------------
`default_nettype none
module homogeneous_point_transform #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] req_point_y,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] req_point_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [hpt_pkg::COORD_W-1:0]      rsp_out_x,
   output logic signed [hpt_pkg::COORD_W-1:0]      rsp_out_y,
   output logic signed [hpt_pkg::COORD_W-1:0]      rsp_out_z,
   output logic                                     rsp_w_is_zero,
   output logic                                     rsp_saturated,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hpt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [hpt_pkg::REG_W-1:0]          csr_data
);
   localparam int RW = hpt_pkg::MAG_W + FRAC_BITS + hpt_pkg::QUO_BITS + 1;
   localparam int CW = hpt_pkg::COORD_W;
   localparam logic [hpt_pkg::REG_W-1:0] ONE_LO = hpt_pkg::REG_W'(1) << FRAC_BITS;
   localparam logic [hpt_pkg::REG_W-1:0] ONE_HI = ONE_LO << CW;

   logic [hpt_pkg::REG_W-1:0]   cfg_ff [hpt_pkg::NUM_REGS];
   logic signed [CW-1:0]        coef [4][4];
   logic                        en;
   hpt_pkg::hpt_mac_ctl_type    mac_ctl;
   logic [RW-1:0]               mac_num [3];
   logic [RW-1:0]               mac_den;
   logic                        dv [3];
   logic [CW-1:0]               dq [3];
   logic                        ds [3];

   logic                        rsp_valid_ff;
   logic [CW-1:0]               out_ff [3];
   logic                        wz_ff, sat_ff;
   logic                        wz_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= ONE_LO;
         cfg_ff[1] <= '0;
         cfg_ff[2] <= ONE_HI;
         cfg_ff[3] <= '0;
         cfg_ff[4] <= '0;
         cfg_ff[5] <= ONE_LO;
         cfg_ff[6] <= '0;
         cfg_ff[7] <= ONE_HI;
      end else if (csr_valid && csr_index < hpt_pkg::CSR_IDX_W'(hpt_pkg::NUM_REGS)) begin
         cfg_ff[csr_index[hpt_pkg::REG_IDX_W-1:0]] <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = (c % 2 == 1) ? cfg_ff[r*2 + c/2][2*CW-1:CW]
                                      : cfg_ff[r*2 + c/2][CW-1:0];
         end
      end
   end

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   hpt_mac #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .px       (req_point_x),
      .py       (req_point_y),
      .pz       (req_point_z),
      .coef     (coef),
      .ctl      (mac_ctl),
      .num      (mac_num),
      .den      (mac_den)
   );

   for (genvar j = 0; j < 3; j++) begin : g_div
      hpt_pkg::hpt_div_ctl_type dctl;
      assign dctl.valid  = mac_ctl.valid;
      assign dctl.w_zero = mac_ctl.w_zero;
      assign dctl.neg    = mac_ctl.neg[j];
      hpt_div #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctl_in    (dctl),
         .num       (mac_num[j]),
         .den       (mac_den),
         .out_valid (dv[j]),
         .quo       (dq[j]),
         .sat       (ds[j])
      );
   end

   // w zero carried alongside the divider pipeline
   logic wz_pipe_ff [hpt_pkg::QUO_BITS+1];
   always_ff @(posedge clock) begin
      if (en) begin
         wz_pipe_ff[0] <= mac_ctl.w_zero;
         for (int k = 0; k < hpt_pkg::QUO_BITS; k++) begin
            wz_pipe_ff[k+1] <= wz_pipe_ff[k];
         end
      end
   end
   assign wz_out = wz_pipe_ff[hpt_pkg::QUO_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv[0] && dv[1] && dv[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            out_ff[j] <= dq[j];
         end
         wz_ff  <= wz_out;
         sat_ff <= ds[0] || ds[1] || ds[2];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_w_is_zero = wz_ff;
   assign rsp_saturated = sat_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/hpt_mac.sv -----
// ---------------------------------------------------------------------------
// hpt_mac
// row vector times matrix: multiply stage, column sum stage, magnitude stage
// ---------------------------------------------------------------------------
`default_nettype none
module hpt_mac #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
   parameter int RW        = hpt_pkg::MAG_W + FRAC_BITS + hpt_pkg::QUO_BITS + 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] px,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] py,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] pz,
   input  wire logic signed [hpt_pkg::COORD_W-1:0] coef [4][4],
   output hpt_pkg::hpt_mac_ctl_type                 ctl,
   output logic [RW-1:0]                            num [3],
   output logic [RW-1:0]                            den
);
   localparam int SW = hpt_pkg::SUM_W;
   localparam int MW = hpt_pkg::MAG_W;

   logic signed [hpt_pkg::PROD_W-1:0] prod_ff [4][3];
   logic signed [SW-1:0]              bias_ff [4];
   logic                              v1_ff, v2_ff, v3_ff;
   logic signed [SW-1:0]              sum_ff  [4];
   logic [RW-1:0]                     num_ff  [3];
   logic [RW-1:0]                     den_ff;
   logic                              wz_ff;
   logic [2:0]                        neg_ff;

   logic signed [hpt_pkg::COORD_W-1:0] pt [3];
   logic [MW-1:0]                      mag [4];
   logic [2:0]                         neg_in;

   assign pt[0] = px;
   assign pt[1] = py;
   assign pt[2] = pz;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mag[c] = sum_ff[c][SW-1] ? MW'(-sum_ff[c]) : MW'(sum_ff[c]);
      end
      for (int j = 0; j < 3; j++) begin
         neg_in[j] = sum_ff[j][SW-1] ^ sum_ff[3][SW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 3; i++) begin
               prod_ff[c][i] <= pt[i] * coef[i][c];
            end
            bias_ff[c] <= SW'(coef[3][c]) <<< FRAC_BITS;
            sum_ff[c]  <= bias_ff[c] + SW'(prod_ff[c][0]) + SW'(prod_ff[c][1])
                          + SW'(prod_ff[c][2]);
         end
         for (int j = 0; j < 3; j++) begin
            num_ff[j] <= RW'(mag[j]) << FRAC_BITS;
         end
         den_ff <= RW'(mag[3]);
         wz_ff  <= (sum_ff[3] == '0);
         neg_ff <= neg_in;
      end
   end

   assign ctl.valid  = v3_ff;
   assign ctl.w_zero = wz_ff;
   assign ctl.neg    = neg_ff;
   assign num        = num_ff;
   assign den        = den_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/hpt_div.sv -----
// ---------------------------------------------------------------------------
// hpt_div
// pipelined restoring divider, one quotient bit per stage, with saturation
// ---------------------------------------------------------------------------
`default_nettype none
module hpt_div #(
   parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
   parameter int RW        = hpt_pkg::MAG_W + FRAC_BITS + hpt_pkg::QUO_BITS + 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  hpt_pkg::hpt_div_ctl_type              ctl_in,
   input  wire logic [RW-1:0]                    num,
   input  wire logic [RW-1:0]                    den,
   output logic                                  out_valid,
   output logic [hpt_pkg::COORD_W-1:0]           quo,
   output logic                                  sat
);
   localparam int QB = hpt_pkg::QUO_BITS;
   localparam int CW = hpt_pkg::COORD_W;

   hpt_pkg::hpt_div_ctl_type ctl_ff [QB+1];
   logic [RW-1:0]            rem_ff [QB+1];
   logic [RW-1:0]            den_ff [QB+1];
   logic                     ovf_ff [QB+1];
   logic [QB-1:0]            q_ff   [QB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            ctl_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         rem_ff[0] <= num;
         den_ff[0] <= den;
         ovf_ff[0] <= (num >= (den << QB));
         q_ff[0]   <= '0;
         for (int k = 0; k < QB; k++) begin
            ctl_ff[k+1] <= ctl_ff[k];
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            if (rem_ff[k] >= (den_ff[k] << (QB - 1 - k))) begin
               rem_ff[k+1] <= rem_ff[k] - (den_ff[k] << (QB - 1 - k));
               q_ff[k+1]   <= q_ff[k] | (QB'(1) << (QB - 1 - k));
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               q_ff[k+1]   <= q_ff[k];
            end
         end
      end
   end

   localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};
   localparam logic [QB-1:0] LIM_NEG = QB'(MIN_NEG);
   localparam logic [QB-1:0] LIM_POS = QB'(MAX_POS);

   always_comb begin
      quo = '0;
      sat = 1'b0;
      if (ctl_ff[QB].w_zero) begin
         quo = '0;
      end else if (ctl_ff[QB].neg) begin
         if (ovf_ff[QB] || q_ff[QB] > LIM_NEG) begin
            quo = MIN_NEG;
            sat = 1'b1;
         end else begin
            quo = CW'(-q_ff[QB]);
         end
      end else begin
         if (ovf_ff[QB] || q_ff[QB] > LIM_POS) begin
            quo = MAX_POS;
            sat = 1'b1;
         end else begin
            quo = CW'(q_ff[QB]);
         end
      end
   end

   assign out_valid = ctl_ff[QB].valid;
endmodule
`default_nettype wire

// ----- hw/rtl/hpt_checker.sv -----
// ---------------------------------------------------------------------------
// hpt_port_checker
// port-level checks of the homogeneous point transform
// ---------------------------------------------------------------------------
`default_nettype none
module hpt_port_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [hpt_pkg::COORD_W-1:0]  rsp_out_x,
   input wire logic [hpt_pkg::COORD_W-1:0]  rsp_out_y,
   input wire logic [hpt_pkg::COORD_W-1:0]  rsp_out_z,
   input wire logic                          rsp_w_is_zero,
   input wire logic                          rsp_saturated
);
   localparam int CW = hpt_pkg::COORD_W;
   localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_wzero_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_w_is_zero |-> !rsp_saturated && rsp_out_x == '0
         && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("w zero result not cleared");

   a_sat_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_out_x == MAX_POS || rsp_out_x == MIN_NEG
         || rsp_out_y == MAX_POS || rsp_out_y == MIN_NEG
         || rsp_out_z == MAX_POS || rsp_out_z == MIN_NEG)
      else $error("saturation flag without clamped coordinate");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z))
      else $error("stalled result changed");
endmodule

bind homogeneous_point_transform hpt_port_checker u_hpt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_x     (rsp_out_x),
   .rsp_out_y     (rsp_out_y),
   .rsp_out_z     (rsp_out_z),
   .rsp_w_is_zero (rsp_w_is_zero),
   .rsp_saturated (rsp_saturated)
);
`default_nettype wire
